### hw/rtl/sync_bus_frame_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sync bus frame engine
// Immediate-implication and next-cycle-implication checks with async reset.
// ----------------------------------------------------------------------------
`ifndef SYNC_BUS_FRAME_ENGINE_ASSERT_SVH
`define SYNC_BUS_FRAME_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define SBFE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sbfe assertion failed");
// next-cycle implication
`define SBFE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sbfe assertion failed");
`else
`define SBFE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SBFE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/sbfe_pkg.sv
// ----------------------------------------------------------------------------
// sbfe_pkg
// Types, frame geometry and codes shared by the sync bus frame engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbfe_pkg;

	// frame geometry
	localparam int TICKS_PER_BIT = 4;
	localparam int START_BITS    = 1;
	localparam int ID_BITS       = 6;
	localparam int DATA_BITS     = 16;
	localparam int CHECK_BITS    = 8;

	// request codes
	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_TX   = 2'd1;
	localparam logic [1:0] REQ_RX   = 2'd2;

	// frame status codes
	localparam logic [1:0] ST_TX_OK   = 2'd0;
	localparam logic [1:0] ST_RX_OK   = 2'd1;
	localparam logic [1:0] ST_RX_MISS = 2'd2;
	localparam logic [1:0] ST_CHK_ERR = 2'd3;

	// configuration register indexes
	localparam logic CFG_NODE_ID = 1'b0;
	localparam logic CFG_TX_WORD = 1'b1;

	typedef struct packed {
		logic [1:0]  req_type;
		logic        line_level;
		logic [15:0] self_cycle_count;
	} in_item_t;

	typedef struct packed {
		logic        drive_level;
		logic        transmitting;
		logic        frame_done;
		logic [1:0]  frame_status;
		logic [5:0]  received_id;
		logic [15:0] received_data;
	} out_item_t;

endpackage

`default_nettype wire

### hw/rtl/sbfe_frame.sv
// ----------------------------------------------------------------------------
// sbfe_frame
// Frame state, configuration registers and per-tick next-state logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbfe_frame (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [15:0]        cfg_wdata,
	input  wire logic               step_en,
	input  wire sbfe_pkg::in_item_t item,
	output sbfe_pkg::out_item_t     result
);
	import sbfe_pkg::*;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_START = 3'd1;
	localparam logic [2:0] PH_ID    = 3'd2;
	localparam logic [2:0] PH_DATA  = 3'd3;
	localparam logic [2:0] PH_CHECK = 3'd4;
	localparam logic [2:0] PH_EVAL  = 3'd5;

	localparam logic [3:0] SUB_LAST   = 4'(TICKS_PER_BIT - 1);
	localparam logic [9:0] TPB_W      = 10'(TICKS_PER_BIT);
	localparam logic [9:0] START_LAST = 10'(TICKS_PER_BIT * START_BITS - 1);

	logic [5:0]  node_id_q;
	logic [15:0] tx_word_q;

	logic [2:0]  phase_q,  phase_d;
	logic        sender_q, sender_d;
	logic [3:0]  sub_q,    sub_d;
	logic [4:0]  bp_q,     bp_d;
	logic [5:0]  rx_id_q,  rx_id_d;
	logic [15:0] rx_data_q, rx_data_d;
	logic [7:0]  rx_chk_q, rx_chk_d;
	logic [7:0]  tx_chk_q, tx_chk_d;
	logic        drive_q,  drive_d;

	// shared bit counter / field bit select
	logic [5:0]  fld_bits;
	logic [31:0] fld_word;
	logic [4:0]  sh;
	logic        tx_bit;
	logic        adv_wrap;
	logic [5:0]  bp_inc;
	logic        fld_end;
	logic [3:0]  adv_sub;
	logic [4:0]  adv_bp;
	logic        sample;
	logic [9:0]  start_cnt;
	logic [7:0]  rx_sum;
	logic        done;
	logic [1:0]  status;

	always_comb begin
		case (phase_q)
			PH_ID: begin
				fld_bits = 6'(ID_BITS);
				fld_word = 32'(node_id_q);
			end
			PH_DATA: begin
				fld_bits = 6'(DATA_BITS);
				fld_word = 32'(tx_word_q);
			end
			default: begin
				fld_bits = 6'(CHECK_BITS);
				fld_word = 32'(tx_chk_q);
			end
		endcase
	end

	assign sh       = 5'(fld_bits - 6'd1) - bp_q;
	assign tx_bit   = fld_word[sh];
	assign adv_wrap = (sub_q >= SUB_LAST);
	assign bp_inc   = {1'b0, bp_q} + 6'd1;
	assign fld_end  = adv_wrap && (bp_inc >= fld_bits);
	assign adv_sub  = adv_wrap ? 4'd0 : sub_q + 4'd1;
	assign adv_bp   = adv_wrap ? (fld_end ? 5'd0 : bp_inc[4:0]) : bp_q;
	assign sample   = (sub_q == 4'd1);
	assign start_cnt = 10'(bp_q) * TPB_W + 10'(sub_q) + 10'd1;
	assign rx_sum   = {2'b00, rx_id_q} + rx_data_q[7:0];

	always_comb begin
		phase_d   = phase_q;
		sender_d  = sender_q;
		sub_d     = sub_q;
		bp_d      = bp_q;
		rx_id_d   = rx_id_q;
		rx_data_d = rx_data_q;
		rx_chk_d  = rx_chk_q;
		tx_chk_d  = tx_chk_q;
		drive_d   = drive_q;
		done      = 1'b0;
		status    = ST_TX_OK;

		if (item.req_type == REQ_TX || item.req_type == REQ_RX) begin
			// start requests only act in idle
			if (phase_q == PH_IDLE) begin
				if (item.req_type == REQ_TX && item.line_level) begin
					sender_d = 1'b1;
					drive_d  = 1'b0;
					phase_d  = PH_START;
				end else begin
					sender_d = 1'b0;
					drive_d  = 1'b1;
				end
				if (phase_d == PH_START || item.req_type == REQ_RX) begin
					phase_d   = PH_START;
					sub_d     = 4'd0;
					bp_d      = 5'd0;
					rx_id_d   = 6'd0;
					rx_data_d = 16'd0;
					rx_chk_d  = 8'd0;
				end
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
				end
				PH_START: begin
					drive_d = !sender_q;
					if (start_cnt >= START_LAST) begin
						sub_d   = 4'd0;
						bp_d    = 5'd0;
						phase_d = PH_ID;
					end else begin
						sub_d = 4'(start_cnt % TICKS_PER_BIT);
						bp_d  = 5'(start_cnt / TICKS_PER_BIT);
					end
				end
				PH_ID: begin
					if (sender_q) begin
						drive_d = tx_bit;
						// lost arbitration: read back differs from driven bit
						if (sample && tx_bit != item.line_level)
							sender_d = 1'b0;
					end
					if (sample)
						rx_id_d = {rx_id_q[4:0], item.line_level};
					sub_d = adv_sub;
					bp_d  = adv_bp;
					if (fld_end)
						phase_d = PH_DATA;
				end
				PH_DATA: begin
					if (sender_q)
						drive_d = tx_bit;
					if (sample)
						rx_data_d = {rx_data_q[14:0], item.line_level};
					sub_d = adv_sub;
					bp_d  = adv_bp;
					if (fld_end) begin
						phase_d  = PH_CHECK;
						tx_chk_d = {2'b00, node_id_q} + tx_word_q[7:0];
					end
				end
				PH_CHECK: begin
					if (sender_q)
						drive_d = tx_bit;
					if (sample)
						rx_chk_d = {rx_chk_q[6:0], item.line_level};
					sub_d = adv_sub;
					bp_d  = adv_bp;
					if (fld_end)
						phase_d = PH_EVAL;
				end
				PH_EVAL: begin
					drive_d = 1'b1;
					done    = 1'b1;
					if (rx_sum != rx_chk_q)
						status = ST_CHK_ERR;
					else if (sender_q)
						status = ST_TX_OK;
					else if (rx_data_q == item.self_cycle_count)
						status = ST_RX_OK;
					else
						status = ST_RX_MISS;
					sender_d = 1'b0;
					sub_d    = 4'd0;
					bp_d     = 5'd0;
					phase_d  = PH_IDLE;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		result.drive_level   = drive_d;
		result.transmitting  = sender_d;
		result.frame_done    = done;
		result.frame_status  = status;
		result.received_id   = rx_id_d;
		result.received_data = rx_data_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= '0;
			tx_word_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NODE_ID: node_id_q <= cfg_wdata[5:0];
				CFG_TX_WORD: tx_word_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			sender_q  <= 1'b0;
			sub_q     <= '0;
			bp_q      <= '0;
			rx_id_q   <= '0;
			rx_data_q <= '0;
			rx_chk_q  <= '0;
			tx_chk_q  <= '0;
			drive_q   <= 1'b1;
		end else if (step_en) begin
			phase_q   <= phase_d;
			sender_q  <= sender_d;
			sub_q     <= sub_d;
			bp_q      <= bp_d;
			rx_id_q   <= rx_id_d;
			rx_data_q <= rx_data_d;
			rx_chk_q  <= rx_chk_d;
			tx_chk_q  <= tx_chk_d;
			drive_q   <= drive_d;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/sync_bus_frame_engine.sv
// ----------------------------------------------------------------------------
// sync_bus_frame_engine
// An accepted tick waits in stage 1 until it retires; its result is then registered and offered.
// Throughput: one tick per cycle unless a low out_ready stalls the result channel.
// Reset (arst_n low, async): idle, receiver role, bus released, registers zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sync_bus_frame_engine_assert.svh"

module sync_bus_frame_engine (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration write port
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [15:0]        cfg_wdata,
	// tick input channel
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire sbfe_pkg::in_item_t in_data,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_ready,
	output sbfe_pkg::out_item_t     out_data
);
	import sbfe_pkg::*;

	// Stage 1: input register. It holds one accepted tick until the frame
	// logic can retire it into the result register.
	logic     in_valid_s1;
	in_item_t in_item_s1;

	// Result register: one result per tick, held until its transfer.
	logic      out_valid_q;
	out_item_t out_item_q;

	// The tick in stage 1 retires when the result register is empty or is
	// being emptied in this very cycle.
	logic      advance;
	out_item_t step_result;

	assign advance  = in_valid_s1 && (!out_valid_q || out_ready);
	// Stage 1 takes a new transfer when empty or when its tick retires.
	assign in_ready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			in_item_s1 <= in_data;
	end

	// Frame state machine: state only moves when a tick retires, so every
	// accepted tick yields exactly one result.
	sbfe_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.step_en   (advance),
		.item      (in_item_s1),
		.result    (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_item_q <= step_result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_item_q;

	// Evaluation always hands the frame back: a done frame is never owned.
	`SBFE_ASSERT_IMP(a_done_releases, clk, arst_n, out_valid_q && out_item_q.frame_done, !out_item_q.transmitting && out_item_q.drive_level)
	// Status is only meaningful on the evaluation tick.
	`SBFE_ASSERT_IMP(a_status_quiet, clk, arst_n, out_valid_q && !out_item_q.frame_done, out_item_q.frame_status == ST_TX_OK)
	// A retired tick always lands in the result register.
	`SBFE_ASSERT_NXT(a_retire_lands, clk, arst_n, advance, out_valid_q)
	// Stage 1 only stalls while it holds a tick.
	`SBFE_ASSERT_IMP(a_stall_holds, clk, arst_n, !in_ready, in_valid_s1 && out_valid_q)

endmodule

`default_nettype wire
